// ----- rtl/core/npcs_pkg.sv -----
// Shared constants and types for the nearest palette color search block.
package npcs_pkg;

   localparam int unsigned PALETTE_ENTRIES = 256;
   localparam int unsigned ADDR_WIDTH      = $clog2(PALETTE_ENTRIES);
   localparam int unsigned CNT_WIDTH       = ADDR_WIDTH + 1;
   localparam int unsigned INDEX_WIDTH     = 8;
   localparam int unsigned CHAN_WIDTH      = 16;
   localparam int unsigned COLOR_WIDTH     = 3 * CHAN_WIDTH;
   localparam int unsigned DIST_WIDTH      = CHAN_WIDTH + 2;

   localparam logic [DIST_WIDTH-1:0] MAX_DISTANCE = DIST_WIDTH'(65535 * 3);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef logic [CHAN_WIDTH-1:0] chan_type;

   function automatic chan_type abs_diff(input chan_type a, input chan_type b);
      chan_type result;
      result = (a > b) ? (a - b) : (b - a);
      return result;
   endfunction

endpackage

// ----- rtl/core/nearest_palette_color_search.sv -----
// Nearest palette color search: palette storage and a sequential Manhattan distance scan.
// A write transaction is taken while the block is idle, and the next transaction may follow at once.
// A query transaction scans every palette entry through one shared distance unit, one entry
// read from the palette memory per cycle, and presents its result once the scan pipeline has
// drained; a new transaction is taken only after that result is loaded into the response register.
// Synchronous reset clears the control state and the per-entry valid bits, so all entries read as zero.
module nearest_palette_color_search
   import npcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [INDEX_WIDTH-1:0] req_entry_index,
   input  logic [CHAN_WIDTH-1:0]  req_red,
   input  logic [CHAN_WIDTH-1:0]  req_green,
   input  logic [CHAN_WIDTH-1:0]  req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [INDEX_WIDTH-1:0] rsp_nearest_index
);

   state_type                   state_ff, state_in;
   logic [CNT_WIDTH-1:0]        issue_cnt_ff, issue_cnt_in;
   logic [ADDR_WIDTH-1:0]       issue_addr;
   logic                        issue_go;
   logic                        req_take;
   logic                        rsp_load;

   logic [COLOR_WIDTH-1:0]      palette_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]  entry_vld_ff;
   logic                        mem_we;
   logic [ADDR_WIDTH-1:0]       wr_addr;

   chan_type                    q_red_ff, q_green_ff, q_blue_ff;

   logic                        s1_vld_ff;
   logic [ADDR_WIDTH-1:0]       s1_idx_ff;
   logic [COLOR_WIDTH-1:0]      rd_data_ff;
   logic                        rd_hit_ff;
   logic [COLOR_WIDTH-1:0]      entry_color;
   logic [DIST_WIDTH-1:0]       dist_in;

   logic                        s2_vld_ff;
   logic [ADDR_WIDTH-1:0]       s2_idx_ff;
   logic [DIST_WIDTH-1:0]       dist_ff;

   logic [DIST_WIDTH-1:0]       best_dist_ff;
   logic [ADDR_WIDTH-1:0]       best_idx_ff;
   logic                        best_found_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [INDEX_WIDTH-1:0]      rsp_index_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign mem_we     = req_take && (req_kind == KIND_WRITE) &&
                       (32'(req_entry_index) < PALETTE_ENTRIES);
   assign wr_addr    = ADDR_WIDTH'(req_entry_index);
   assign issue_addr = issue_cnt_ff[ADDR_WIDTH-1:0];
   assign issue_go   = (state_ff == ST_SCAN) && (issue_cnt_ff < CNT_WIDTH'(PALETTE_ENTRIES));
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_kind == KIND_QUERY)) begin
               state_in     = ST_SCAN;
               issue_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            if (issue_go) begin
               issue_cnt_in = issue_cnt_ff + CNT_WIDTH'(1);
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[wr_addr] <= {req_red, req_green, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= palette_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (mem_we) begin
         entry_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_kind == KIND_QUERY)) begin
         q_red_ff   <= req_red;
         q_green_ff <= req_green;
         q_blue_ff  <= req_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue_go;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= issue_addr;
      rd_hit_ff <= entry_vld_ff[issue_addr];
      s2_idx_ff <= s1_idx_ff;
      dist_ff   <= dist_in;
   end

   assign entry_color = rd_hit_ff ? rd_data_ff : '0;
   assign dist_in = DIST_WIDTH'(abs_diff(q_red_ff,   entry_color[3*CHAN_WIDTH-1:2*CHAN_WIDTH]))
                  + DIST_WIDTH'(abs_diff(q_green_ff, entry_color[2*CHAN_WIDTH-1:CHAN_WIDTH]))
                  + DIST_WIDTH'(abs_diff(q_blue_ff,  entry_color[CHAN_WIDTH-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
         best_idx_ff   <= '0;
         best_dist_ff  <= MAX_DISTANCE;
      end else if (req_take && (req_kind == KIND_QUERY)) begin
         best_found_ff <= 1'b0;
         best_idx_ff   <= '0;
         best_dist_ff  <= MAX_DISTANCE;
      end else if (s2_vld_ff && (dist_ff < best_dist_ff)) begin
         best_found_ff <= 1'b1;
         best_idx_ff   <= s2_idx_ff;
         best_dist_ff  <= dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= best_found_ff;
         rsp_index_ff <= INDEX_WIDTH'(best_idx_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_index = rsp_index_ff;

   a_pipe_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("Distance pipeline is active outside the scan.");

   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= CNT_WIDTH'(PALETTE_ENTRIES))
      else $error("Scan counter ran past the last palette entry.");

   a_no_hit_index_zero: assert property (@(posedge clock) disable iff (reset)
      !best_found_ff |-> (best_idx_ff == '0))
      else $error("Best index is nonzero without a hit.");

   a_found_matches_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (best_found_ff == (best_dist_ff < MAX_DISTANCE)))
      else $error("Found flag disagrees with the best distance.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("A response transaction appeared without a finished scan.");

endmodule

// ----- bench/palette_search_checker.sv -----
// Checker for the nearest palette color search: mirrors the palette and compares every result.
`timescale 1ns / 100ps

module palette_search_checker
   import npcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_kind,
   input  logic [INDEX_WIDTH-1:0] req_entry_index,
   input  logic [CHAN_WIDTH-1:0]  req_red,
   input  logic [CHAN_WIDTH-1:0]  req_green,
   input  logic [CHAN_WIDTH-1:0]  req_blue,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_found,
   input  logic [INDEX_WIDTH-1:0] rsp_nearest_index,
   output int                     error_count,
   output int                     pending_results,
   output int                     results_checked,
   output int                     empty_results
);

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
   } match_type;

   logic [COLOR_WIDTH-1:0] palette_copy [PALETTE_ENTRIES];
   match_type              expected_matches [$];
   match_type              want;
   int                     errors   = 0;
   int                     pending  = 0;
   int                     checked  = 0;
   int                     empties  = 0;

   assign error_count     = errors;
   assign pending_results = pending;
   assign results_checked = checked;
   assign empty_results   = empties;

   function automatic int chan_gap(input chan_type a, input chan_type b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic match_type closest_entry(input chan_type red, input chan_type green,
                                               input chan_type blue);
      match_type              best;
      int                     best_dist;
      int                     gap_sum;
      logic [COLOR_WIDTH-1:0] color;
      best      = '0;
      best_dist = int'(MAX_DISTANCE);
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         color   = palette_copy[i];
         gap_sum = chan_gap(red,   color[COLOR_WIDTH-1 -: CHAN_WIDTH])
                 + chan_gap(green, color[2*CHAN_WIDTH-1 -: CHAN_WIDTH])
                 + chan_gap(blue,  color[CHAN_WIDTH-1:0]);
         if (gap_sum < best_dist) begin
            best_dist  = gap_sum;
            best.found = 1'b1;
            best.index = INDEX_WIDTH'(i);
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            palette_copy[i] = '0;
         end
         expected_matches.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual found %0d index %0d",
                        $time, rsp_found, rsp_nearest_index);
            end else begin
               want = expected_matches.pop_front();
               checked++;
               if (!want.found) begin
                  empties++;
               end
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found mismatch, expected %0d, actual %0d",
                           $time, want.found, rsp_found);
               end
               if (rsp_nearest_index !== want.index) begin
                  errors++;
                  $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                           $time, want.index, rsp_nearest_index);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_WRITE) begin
               palette_copy[req_entry_index] = {req_red, req_green, req_blue};
            end else begin
               expected_matches.push_back(closest_entry(req_red, req_green, req_blue));
            end
         end
      end
      pending = expected_matches.size();
   end

endmodule

// ----- bench/tb_nearest_palette_color_search.sv -----
// Testbench top for the nearest palette color search: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_nearest_palette_color_search;
   import npcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [INDEX_WIDTH-1:0] req_entry_index;
   logic [CHAN_WIDTH-1:0]  req_red;
   logic [CHAN_WIDTH-1:0]  req_green;
   logic [CHAN_WIDTH-1:0]  req_blue;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_found;
   logic [INDEX_WIDTH-1:0] rsp_nearest_index;

   int error_count;
   int pending_results;
   int results_checked;
   int empty_results;
   int idle_cycles  = 0;
   int items_sent   = 0;
   bit steady_phase = 1'b0;

   logic [COLOR_WIDTH-1:0] written [PALETTE_ENTRIES];

   nearest_palette_color_search u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_nearest_index (rsp_nearest_index)
   );

   palette_search_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_nearest_index (rsp_nearest_index),
      .error_count       (error_count),
      .pending_results   (pending_results),
      .results_checked   (results_checked),
      .empty_results     (empty_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (!steady_phase && $urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall = 1'b0;
         end
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   function automatic chan_type random_chan();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end
      return chan_type'($urandom_range(0, 65535));
   endfunction

   function automatic chan_type nudge(input chan_type base);
      int v;
      if ($urandom_range(0, 3) == 0) begin
         return base;
      end
      v = int'(base) + $urandom_range(0, 400) - 200;
      if (v < 0) begin
         v = 0;
      end else if (v > 65535) begin
         v = 65535;
      end
      return chan_type'(v);
   endfunction

   task automatic send_item(input logic kind, input logic [INDEX_WIDTH-1:0] index,
                            input chan_type red, input chan_type green, input chan_type blue);
      int gap;
      if (!steady_phase && $urandom_range(0, 4) == 0) begin
         gap       = $urandom_range(1, 10);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind        = kind;
      req_entry_index = index;
      req_red         = red;
      req_green       = green;
      req_blue        = blue;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (kind == KIND_WRITE) begin
         written[index] = {red, green, blue};
      end
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
   endtask

   task automatic random_mix_item();
      int                     pick;
      logic [INDEX_WIDTH-1:0] idx;
      logic [COLOR_WIDTH-1:0] color;
      pick  = $urandom_range(0, 9);
      idx   = INDEX_WIDTH'($urandom_range(0, 255));
      color = written[idx];
      if (pick < 4) begin
         send_item(KIND_WRITE, idx, random_chan(), random_chan(), random_chan());
      end else if (pick < 7) begin
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)), random_chan(),
                   random_chan(), random_chan());
      end else begin
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)),
                   nudge(color[COLOR_WIDTH-1 -: CHAN_WIDTH]),
                   nudge(color[2*CHAN_WIDTH-1 -: CHAN_WIDTH]),
                   nudge(color[CHAN_WIDTH-1:0]));
      end
   endtask

   initial begin
      logic [2:0]             corner;
      chan_type               cr, cg, cb;
      logic [INDEX_WIDTH-1:0] lo_idx, hi_idx, spot;
      chan_type               tr, tg, tb;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_WRITE;
      req_entry_index = '0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         written[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The cleared palette matches black at entry zero and leaves white with no match.
      send_item(KIND_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      send_item(KIND_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_QUERY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_QUERY, 8'h55, 16'h8000, 16'h8000, 16'h8000);
      send_item(KIND_WRITE, 8'h00, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(KIND_WRITE, 8'h80, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(KIND_WRITE, 8'h01, 16'h0000, 16'h0000, 16'hFFFF);
      send_item(KIND_QUERY, 8'hAA, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(KIND_QUERY, 8'h00, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(KIND_QUERY, 8'hFF, 16'h0000, 16'h0000, 16'hFFFF);
      // Two entries with the same color: the lower index must win the tie.
      send_item(KIND_WRITE, 8'h14, 16'h1234, 16'h5678, 16'h9ABC);
      send_item(KIND_WRITE, 8'h0A, 16'h1234, 16'h5678, 16'h9ABC);
      send_item(KIND_QUERY, 8'h00, 16'h1234, 16'h5678, 16'h9ABC);
      send_item(KIND_QUERY, 8'h00, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_item(KIND_WRITE, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
      send_item(KIND_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();

      repeat (600) random_mix_item();
      drain_results();

      // Fill the whole palette with one corner so the opposite corner finds nothing.
      repeat (2) begin
         corner = 3'($urandom_range(0, 7));
         cr = corner[2] ? '1 : '0;
         cg = corner[1] ? '1 : '0;
         cb = corner[0] ? '1 : '0;
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            send_item(KIND_WRITE, INDEX_WIDTH'(i), cr, cg, cb);
         end
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)), ~cr, ~cg, ~cb);
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)), cr, cg, cb);
         spot = INDEX_WIDTH'($urandom_range(0, 255));
         send_item(KIND_WRITE, spot, nudge(cr), nudge(cg), nudge(cb));
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)), ~cr, ~cg, ~cb);
      end
      drain_results();

      repeat (50) begin
         lo_idx = INDEX_WIDTH'($urandom_range(0, 254));
         hi_idx = INDEX_WIDTH'($urandom_range(lo_idx + 1, 255));
         tr     = random_chan();
         tg     = random_chan();
         tb     = random_chan();
         if ($urandom_range(0, 1) == 0) begin
            send_item(KIND_WRITE, hi_idx, tr, tg, tb);
            send_item(KIND_WRITE, lo_idx, tr, tg, tb);
         end else begin
            send_item(KIND_WRITE, lo_idx, tr, tg, tb);
            send_item(KIND_WRITE, hi_idx, tr, tg, tb);
         end
         send_item(KIND_QUERY, INDEX_WIDTH'($urandom_range(0, 255)), tr, tg, tb);
      end

      steady_phase = 1'b1;
      repeat (160) random_mix_item();
      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d transactions of palette writes and nearest-color queries.", items_sent);
      $display("Checked %0d query results, %0d of them with no entry in range.",
               results_checked, empty_results);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
